// ===== design/compacting_list_store_macros.svh =====
// ----------------------------------------------------------------------------
// compacting_list_store_macros.svh
// Assertion shorthands, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_LIST_STORE_MACROS_SVH
`define COMPACTING_LIST_STORE_MACROS_SVH

// same-cycle implication
`define CLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/clm_pkg.sv =====
// ----------------------------------------------------------------------------
// clm_pkg
// Types and constants shared by the list store and its cells.
// ----------------------------------------------------------------------------
package clm_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned IdxW         = 10;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CountOutW    = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } clm_op_e;

  typedef struct packed {
    clm_op_e              opcode;
    logic [IdxW-1:0]      index;
    logic [DataW-1:0]     value;
  } clm_in_t;

  typedef struct packed {
    logic [DataW-1:0]     read_value;
    logic                 ok;
    logic [CountOutW-1:0] count;
    logic                 is_empty;
  } clm_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic append_en;
    logic remove_en;
    logic capture_en;
    logic shift_en;
  } clm_cell_cmd_t;

endpackage

// ===== design/clm_cell.sv =====
// ----------------------------------------------------------------------------
// clm_cell
// One list slot: holds its entry, takes its upper neighbor's entry on a
// remove, and carries one stage of the read chain toward slot zero.
// ----------------------------------------------------------------------------
module clm_cell import clm_pkg::*; #(
  parameter int unsigned Pos    = 0,
  parameter int unsigned CountW = 5
) (
  input  logic                clk_i,
  input  clm_cell_cmd_t       cmd_i,
  input  logic [IdxW-1:0]     index_i,
  input  logic [CountW-1:0]   count_i,
  input  logic [DataW-1:0]    value_i,
  input  logic [DataW-1:0]    next_entry_i,
  input  logic [DataW-1:0]    next_rd_i,
  output logic [DataW-1:0]    entry_o,
  output logic [DataW-1:0]    rd_o
);

  logic [DataW-1:0] entry_q, entry_d;
  logic [DataW-1:0] rd_q, rd_d;
  logic             hit;
  logic             at_tail;
  logic             take_next;

  assign hit       = (index_i == IdxW'(Pos));
  assign at_tail   = (count_i == CountW'(Pos));
  // slots from the removed one up to the second-to-last move down
  assign take_next = (index_i <= IdxW'(Pos)) && (CountW'(Pos + 1) < count_i);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.append_en && at_tail) begin
      entry_d = value_i;
    end else if (cmd_i.remove_en && take_next) begin
      entry_d = next_entry_i;
    end
  end

  always_comb begin
    rd_d = rd_q;
    if (cmd_i.capture_en) begin
      rd_d = hit ? entry_q : '0;
    end else if (cmd_i.shift_en) begin
      rd_d = next_rd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rd_q    <= rd_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_q;

endmodule

// ===== design/compacting_list_store.sv =====
// ----------------------------------------------------------------------------
// compacting_list_store - ordered list store built as a row of slot cells
// Append, clear, a failed get/remove and a hit at index 0: one word per cycle
// while the output is not stalled. A get/remove hit at index k: the read word walks
// down the cell chain one slot per cycle to slot zero, and the next word is taken
// when it leaves. Reset (rst_ni low) empties the list.
// ----------------------------------------------------------------------------
`include "compacting_list_store_macros.svh"

module compacting_list_store import clm_pkg::*; #(
  parameter int unsigned Depth = DepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  clm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output clm_out_t out_data_o
);

  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned CntW   = $clog2(Depth);
  localparam int unsigned CmpW   = (CountW > IdxW) ? CountW : IdxW;

  logic [CountW-1:0]    count_q, count_d;
  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 pend_read_q, pend_read_d;
  logic                 pend_ok_q, pend_ok_d;
  logic [CountOutW-1:0] pend_count_q, pend_count_d;
  logic                 pend_empty_q, pend_empty_d;
  logic                 out_valid_q, out_valid_d;
  clm_out_t             out_data_q, out_data_d;

  logic                 in_acc;
  logic                 out_free;
  logic                 done;
  logic                 full;
  logic                 idx_ok;
  logic                 op_ok;
  clm_cell_cmd_t        cmd;

  logic                 app_full_acc;
  logic                 clear_acc;
  logic [CountW-1:0]    count_dec;

  logic [DataW-1:0]     entry_w [Depth];
  logic [DataW-1:0]     rd_w    [Depth];

  assign out_free   = !out_valid_q || out_ready_i;
  assign done       = busy_q && (cnt_q == '0) && out_free;
  assign in_ready_o = !busy_q || done;
  assign in_acc     = in_valid_i && in_ready_o;

  assign full   = (count_q == CountW'(Depth));
  assign idx_ok = (CmpW'(in_data_i.index) < CmpW'(count_q));

  always_comb begin
    cmd            = '0;
    cmd.append_en  = in_acc && (in_data_i.opcode == OP_APPEND) && !full;
    cmd.remove_en  = in_acc && (in_data_i.opcode == OP_REMOVE) && idx_ok;
    cmd.capture_en = in_acc && idx_ok &&
                     ((in_data_i.opcode == OP_GET) || (in_data_i.opcode == OP_REMOVE));
    cmd.shift_en   = busy_q && (cnt_q != '0);
  end

  always_comb begin
    count_d = count_q;
    op_ok   = 1'b0;
    unique case (in_data_i.opcode)
      OP_APPEND: begin
        op_ok = !full;
        if (!full) count_d = count_q + CountW'(1);
      end
      OP_GET: begin
        op_ok = idx_ok;
      end
      OP_REMOVE: begin
        op_ok = idx_ok;
        if (idx_ok) count_d = count_q - CountW'(1);
      end
      OP_CLEAR: begin
        op_ok   = 1'b1;
        count_d = '0;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
    if (!in_acc) count_d = count_q;
  end

  always_comb begin
    busy_d       = busy_q;
    cnt_d        = cnt_q;
    pend_read_d  = pend_read_q;
    pend_ok_d    = pend_ok_q;
    pend_count_d = pend_count_q;
    pend_empty_d = pend_empty_q;
    if (in_acc) begin
      busy_d       = 1'b1;
      cnt_d        = cmd.capture_en ? in_data_i.index[CntW-1:0] : '0;
      pend_read_d  = cmd.capture_en;
      pend_ok_d    = op_ok;
      pend_count_d = CountOutW'(count_d);
      pend_empty_d = (count_d == '0);
    end else if (done) begin
      busy_d = 1'b0;
    end else if (cmd.shift_en) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (done) begin
      out_valid_d           = 1'b1;
      out_data_d.read_value = pend_read_q ? rd_w[0] : '0;
      out_data_d.ok         = pend_ok_q;
      out_data_d.count      = pend_count_q;
      out_data_d.is_empty   = pend_empty_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_read_q  <= pend_read_d;
    pend_ok_q    <= pend_ok_d;
    pend_count_q <= pend_count_d;
    pend_empty_q <= pend_empty_d;
    out_data_q   <= out_data_d;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataW-1:0] next_entry;
    logic [DataW-1:0] next_rd;
    if (i == Depth - 1) begin : g_last
      assign next_entry = '0;
      assign next_rd    = '0;
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
      assign next_rd    = rd_w[i+1];
    end
    clm_cell #(
      .Pos    (i),
      .CountW (CountW)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .index_i      (in_data_i.index),
      .count_i      (count_q),
      .value_i      (in_data_i.value),
      .next_entry_i (next_entry),
      .next_rd_i    (next_rd),
      .entry_o      (entry_w[i]),
      .rd_o         (rd_w[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign app_full_acc = in_acc && (in_data_i.opcode == OP_APPEND) && full;
  assign clear_acc    = in_acc && (in_data_i.opcode == OP_CLEAR);
  assign count_dec    = count_q - CountW'(1);

  `CLM_ASSERT_NXT(a_full_append_holds, app_full_acc, $stable(count_q), "full append moved count")
  `CLM_ASSERT_NXT(a_remove_decrements, cmd.remove_en, count_q == $past(count_dec), "count off")
  `CLM_ASSERT_NXT(a_clear_empties, clear_acc, count_q == '0, "clear left entries")
  `CLM_ASSERT_IMP(a_no_accept_in_walk, cmd.shift_en, !in_ready_o, "word taken mid walk")

endmodule
